// ===== sv/spi_angle_sensor_multiturn_reader_assert.svh =====
// Assertion macros used by the angle sensor reader top level.
`ifndef SPI_ANGLE_SENSOR_MULTITURN_READER_ASSERT_SVH
`define SPI_ANGLE_SENSOR_MULTITURN_READER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define SAMR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("samr assertion failed");

// Check that a condition is never true outside reset.
`define SAMR_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("samr forbidden condition seen");

`else

`define SAMR_ASSERT(label, prop)
`define SAMR_ASSERT_NEVER(label, cond)

`endif

`endif

// ===== sv/samr_pkg.sv =====
// Package with types, constants and helpers of the angle sensor reader.
`timescale 1ns / 1ps
`default_nettype none

package samr_pkg;

  localparam int ANGLE_BITS  = 14;
  localparam int ACCUM_WIDTH = 32;

  // Sensor register addresses and the NOP frame.
  localparam logic [13:0] ADDR_ANGLE = 14'h3FFF;
  localparam logic [13:0] ADDR_CLEAR = 14'h0001;
  localparam logic [15:0] FRAME_NOP  = 16'h0000;

  localparam logic [13:0] WRAP_THRESHOLD_RESET = 14'd15565;

  // Command codes of an input beat.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_REPLY = 2'd1;
  localparam logic [1:0] CMD_ZERO  = 2'd2;

  // Phases of one angle read sequence.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RD,
    PH_RD_NOP,
    PH_CL,
    PH_CL_NOP,
    PH_RT,
    PH_RT_NOP
  } phase_t;

  // Control from the frame sequencer to the datapath.
  typedef struct packed {
    logic        send_valid;
    logic [15:0] send_frame;
    logic        use_data;
  } seq_ctl_t;

  // Read command frame: even parity in bit 15, read bit in bit 14.
  function automatic logic [15:0] read_frame(input logic [13:0] addr);
    logic [15:0] w;
    w = {2'b01, addr};
    return {^w, w[14:0]};
  endfunction

  // A reply is bad when its parity is odd or its error bit is set.
  function automatic logic reply_bad(input logic [15:0] f);
    return (^f) | f[14];
  endfunction

endpackage

`default_nettype wire

// ===== sv/samr_if.sv =====
// Valid/ready channel interfaces for the input and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface samr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] rx_frame;

  modport source (output valid, cmd, rx_frame, input ready);
  modport sink (input valid, cmd, rx_frame, output ready);
endinterface

interface samr_out_if;
  logic               valid;
  logic               ready;
  logic               send_valid;
  logic [15:0]        send_frame;
  logic               done_res;
  logic [13:0]        angle;
  logic signed [31:0] total_counts;
  logic               error_flag;

  modport source (output valid, send_valid, send_frame, done_res, angle, total_counts,
                  error_flag, input ready);
  modport sink (input valid, send_valid, send_frame, done_res, angle, total_counts,
                error_flag, output ready);
endinterface

`default_nettype wire

// ===== sv/samr_seq.sv =====
// Frame sequencer: read, NOP, clear-error and retry phases of a sensor read.
`timescale 1ns / 1ps
`default_nettype none

module samr_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire logic [1:0]       cmd,
  input  wire logic [15:0]      rx_frame,
  output samr_pkg::seq_ctl_t    ctl
);

  samr_pkg::phase_t phase;
  samr_pkg::phase_t phase_next;

  // Phase register, moved only when a beat goes through.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= samr_pkg::PH_IDLE;
    end else if (adv) begin
      phase <= phase_next;
    end
  end

  // Next phase and the frame to send for the current beat.
  always_comb begin
    phase_next     = phase;
    ctl.send_valid = 1'b0;
    ctl.send_frame = samr_pkg::FRAME_NOP;
    ctl.use_data   = 1'b0;
    if (cmd == samr_pkg::CMD_START) begin
      // A start drops any running sequence.
      phase_next     = samr_pkg::PH_RD;
      ctl.send_valid = 1'b1;
      ctl.send_frame = samr_pkg::read_frame(samr_pkg::ADDR_ANGLE);
    end else if (cmd == samr_pkg::CMD_REPLY) begin
      case (phase)
        samr_pkg::PH_IDLE: begin
          phase_next = samr_pkg::PH_IDLE;
        end
        samr_pkg::PH_RD: begin
          phase_next     = samr_pkg::PH_RD_NOP;
          ctl.send_valid = 1'b1;
        end
        samr_pkg::PH_RD_NOP: begin
          if (samr_pkg::reply_bad(rx_frame)) begin
            phase_next     = samr_pkg::PH_CL;
            ctl.send_valid = 1'b1;
            ctl.send_frame = samr_pkg::read_frame(samr_pkg::ADDR_CLEAR);
          end else begin
            phase_next   = samr_pkg::PH_IDLE;
            ctl.use_data = 1'b1;
          end
        end
        samr_pkg::PH_CL: begin
          phase_next     = samr_pkg::PH_CL_NOP;
          ctl.send_valid = 1'b1;
        end
        samr_pkg::PH_CL_NOP: begin
          phase_next     = samr_pkg::PH_RT;
          ctl.send_valid = 1'b1;
          ctl.send_frame = samr_pkg::read_frame(samr_pkg::ADDR_ANGLE);
        end
        samr_pkg::PH_RT: begin
          phase_next     = samr_pkg::PH_RT_NOP;
          ctl.send_valid = 1'b1;
        end
        samr_pkg::PH_RT_NOP: begin
          // The retry data is used whatever its parity.
          phase_next   = samr_pkg::PH_IDLE;
          ctl.use_data = 1'b1;
        end
        default: begin
          phase_next = samr_pkg::PH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/spi_angle_sensor_multiturn_reader.sv =====
// Top level: SPI frame sequencing and multi-turn unwrap of a 14-bit angle sensor.
//
//   channel   dir   handshake        beat contents
//   in_ch     in    valid/ready      cmd, rx_frame
//   out_ch    out   valid/ready      send_valid, send_frame, done_res, angle,
//                                    total_counts, error_flag
//   cfg       in    cfg_we           cfg_wdata (wrap threshold)
//
// Each input beat produces one result beat after it is accepted; it passes through
// the input register and then the result register.
// One beat per cycle is sustained while the sink does not stall; the unwrap add and compare set the path.
// A stalled result register still lets one more beat wait in the input register.
// Reset is synchronous; it clears the phase, the angles and the accumulator and
// loads the default threshold.
`timescale 1ns / 1ps
`default_nettype none
`include "spi_angle_sensor_multiturn_reader_assert.svh"

module spi_angle_sensor_multiturn_reader (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [13:0] cfg_wdata,
  samr_in_if.sink          in_ch,
  samr_out_if.source       out_ch
);

  localparam logic [samr_pkg::ACCUM_WIDTH-1:0] TURN =
    samr_pkg::ACCUM_WIDTH'(1) << samr_pkg::ANGLE_BITS;

  // Input register.
  logic        s1_valid;
  logic [1:0]  s1_cmd;
  logic [15:0] s1_rx;

  // Block state.
  logic [13:0]                       wrap_threshold;
  logic [samr_pkg::ANGLE_BITS-1:0]   last_raw_angle;
  logic [samr_pkg::ANGLE_BITS-1:0]   last_raw_angle_next;
  logic [samr_pkg::ANGLE_BITS-1:0]   offset_angle;
  logic [samr_pkg::ACCUM_WIDTH-1:0]  turn_accumulator;
  logic [samr_pkg::ACCUM_WIDTH-1:0]  turn_accumulator_next;

  // Result register.
  logic out_valid;

  logic                             out_free;
  logic                             adv;
  logic                             in_take;
  samr_pkg::seq_ctl_t               ctl;
  logic [samr_pkg::ANGLE_BITS-1:0]  raw;
  logic [samr_pkg::ANGLE_BITS-1:0]  mag;
  logic                             wrap;
  logic [samr_pkg::ACCUM_WIDTH-1:0] total;

  // Handshake: the input register moves on whenever the result register frees.
  assign out_free    = !out_valid || out_ch.ready;
  assign adv         = s1_valid && out_free;
  assign in_ch.ready = !s1_valid || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd <= in_ch.cmd;
      s1_rx  <= in_ch.rx_frame;
    end
  end

  // Frame sequencer.
  samr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .cmd      (s1_cmd),
    .rx_frame (s1_rx),
    .ctl      (ctl)
  );

  // Unwrap: a jump of at least the threshold counts as a full turn.
  always_comb begin
    raw  = s1_rx[samr_pkg::ANGLE_BITS-1:0];
    mag  = (raw >= last_raw_angle) ? raw - last_raw_angle : last_raw_angle - raw;
    wrap = ctl.use_data && (mag >= wrap_threshold);
    turn_accumulator_next = turn_accumulator;
    if (wrap) begin
      if (raw < last_raw_angle) begin
        turn_accumulator_next = turn_accumulator + TURN;
      end else begin
        turn_accumulator_next = turn_accumulator - TURN;
      end
    end
    last_raw_angle_next = ctl.use_data ? raw : last_raw_angle;
    total = turn_accumulator_next + samr_pkg::ACCUM_WIDTH'(last_raw_angle_next);
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_threshold <= samr_pkg::WRAP_THRESHOLD_RESET;
    end else if (cfg_we) begin
      wrap_threshold <= cfg_wdata;
    end
  end

  // Angle and turn state, updated as each beat goes through.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw_angle   <= '0;
      turn_accumulator <= '0;
      offset_angle     <= '0;
    end else if (adv) begin
      last_raw_angle   <= last_raw_angle_next;
      turn_accumulator <= turn_accumulator_next;
      if (s1_cmd == samr_pkg::CMD_ZERO) begin
        offset_angle <= last_raw_angle;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.send_valid   <= ctl.send_valid;
      out_ch.send_frame   <= ctl.send_frame;
      out_ch.done_res     <= ctl.use_data;
      out_ch.angle        <= ctl.use_data ? 14'(raw - offset_angle) : 14'd0;
      out_ch.total_counts <= signed'(32'(total));
      out_ch.error_flag   <= ctl.use_data && samr_pkg::reply_bad(s1_rx);
    end
  end

  // A completed read never also asks for a frame to be sent.
  `SAMR_ASSERT_NEVER(a_done_no_send, out_valid && out_ch.done_res && out_ch.send_valid)

  // Angle and error flag stay zero on beats that complete no read.
  `SAMR_ASSERT(a_idle_fields_zero,
               out_valid && !out_ch.done_res |-> out_ch.angle == 14'd0 && !out_ch.error_flag)

  // Only the angle read, clear-error read and NOP frames are ever sent.
  `SAMR_ASSERT(a_known_frame,
               out_valid && out_ch.send_valid |->
               out_ch.send_frame == samr_pkg::read_frame(samr_pkg::ADDR_ANGLE) ||
               out_ch.send_frame == samr_pkg::read_frame(samr_pkg::ADDR_CLEAR) ||
               out_ch.send_frame == samr_pkg::FRAME_NOP)

  // Input back-pressure only when both registers hold a beat and the sink stalls.
  `SAMR_ASSERT(a_stall_cause, !in_ch.ready |-> s1_valid && out_valid && !out_ch.ready)

endmodule

`default_nettype wire

// ===== tb/tb_spi_angle_sensor_multiturn_reader.sv =====
// Self-checking testbench for the SPI angle sensor multi-turn reader.
`timescale 1ns / 1ps

module tb_spi_angle_sensor_multiturn_reader;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [31:0] TURN_COUNTS = 32'd1 << samr_pkg::ANGLE_BITS;
  localparam int          PHASE_BEATS = 160;

  // One result beat, field for field as the block presents it.
  typedef struct packed {
    logic        send_valid;
    logic [15:0] send_frame;
    logic        done_res;
    logic [13:0] angle;
    logic [31:0] total_counts;
    logic        error_flag;
  } reader_beat_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [13:0] cfg_wdata;

  samr_in_if  in_ch();
  samr_out_if out_ch();

  spi_angle_sensor_multiturn_reader dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Our own copy of the reader state and its threshold register.
  samr_pkg::phase_t rd_phase;
  logic [13:0]      last_raw;
  logic [13:0]      model_offset;
  logic [13:0]      wrap_thresh;
  logic [31:0]      turn_accum;

  reader_beat_t results_due[$];

  int  errors = 0;
  int  sent_beats = 0;
  int  useful_beats = 0;
  int  reads_done = 0;
  int  reads_flagged = 0;
  int  recoveries = 0;
  int  turn_wraps = 0;
  int  threshold_writes = 0;
  int  stall_left = 0;
  bit  gaps_on = 1'b1;
  bit  stall_on = 1'b1;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("TIMEOUT: results still outstanding: %0d", results_due.size());
    $display("tb_spi_angle_sensor_multiturn_reader NOT OK");
    $finish;
  end

  // Read command frame with even parity over all 16 bits.
  function automatic logic [15:0] cmd_frame(input logic [13:0] addr);
    logic [15:0] f;
    f = {2'b01, addr};
    f[15] = ^f[14:0];
    return f;
  endfunction

  // A reply is unusable if its parity is odd or its error bit is set.
  function automatic logic frame_bad(input logic [15:0] f);
    return (^f) | f[14];
  endfunction

  function automatic logic [15:0] good_reply(input logic [13:0] d);
    return {^d, 1'b0, d};
  endfunction

  // Corrupt a reply: bad parity, error bit alone, or error bit with bad parity.
  function automatic logic [15:0] bad_reply(input logic [13:0] d);
    logic [15:0] f;
    f = good_reply(d);
    case ($urandom_range(0, 2))
      0: f[15] = ~f[15];
      1: f = {~f[15], 1'b1, d};
      default: f[14] = 1'b1;
    endcase
    return f;
  endfunction

  // Angles biased toward small steps and jumps near the wrap threshold.
  function automatic logic [13:0] pick_angle();
    int          r;
    logic [13:0] jump;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return 14'($urandom);
    end else if (r < 7) begin
      return last_raw + 14'($urandom_range(0, 64)) - 14'd32;
    end
    jump = wrap_thresh + 14'($urandom_range(0, 6)) - 14'd3;
    return ($urandom_range(0, 1) != 0) ? last_raw + jump : last_raw - jump;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Advance the reader by one input beat and return the result it must give.
  function automatic reader_beat_t advance_reader(input logic [1:0] c, input logic [15:0] f);
    reader_beat_t r;
    logic         take;
    logic [13:0]  raw;
    logic [13:0]  span;
    r = '0;
    take = 1'b0;
    case (c)
      samr_pkg::CMD_START: begin
        rd_phase = samr_pkg::PH_RD;
        r.send_valid = 1'b1;
        r.send_frame = cmd_frame(samr_pkg::ADDR_ANGLE);
      end
      samr_pkg::CMD_ZERO: begin
        model_offset = last_raw;
      end
      samr_pkg::CMD_REPLY: begin
        case (rd_phase)
          samr_pkg::PH_RD: begin
            rd_phase = samr_pkg::PH_RD_NOP;
            r.send_valid = 1'b1;
            r.send_frame = samr_pkg::FRAME_NOP;
          end
          samr_pkg::PH_RD_NOP: begin
            if (frame_bad(f)) begin
              rd_phase = samr_pkg::PH_CL;
              r.send_valid = 1'b1;
              r.send_frame = cmd_frame(samr_pkg::ADDR_CLEAR);
              recoveries++;
            end else begin
              rd_phase = samr_pkg::PH_IDLE;
              take = 1'b1;
            end
          end
          samr_pkg::PH_CL: begin
            rd_phase = samr_pkg::PH_CL_NOP;
            r.send_valid = 1'b1;
            r.send_frame = samr_pkg::FRAME_NOP;
          end
          samr_pkg::PH_CL_NOP: begin
            rd_phase = samr_pkg::PH_RT;
            r.send_valid = 1'b1;
            r.send_frame = cmd_frame(samr_pkg::ADDR_ANGLE);
          end
          samr_pkg::PH_RT: begin
            rd_phase = samr_pkg::PH_RT_NOP;
            r.send_valid = 1'b1;
            r.send_frame = samr_pkg::FRAME_NOP;
          end
          samr_pkg::PH_RT_NOP: begin
            rd_phase = samr_pkg::PH_IDLE;
            take = 1'b1;
          end
          default: begin
            rd_phase = samr_pkg::PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase

    // Unwrap the new angle against the previous one.
    if (take) begin
      raw = f[13:0];
      span = (raw >= last_raw) ? raw - last_raw : last_raw - raw;
      if (span >= wrap_thresh) begin
        turn_accum = (raw < last_raw) ? turn_accum + TURN_COUNTS : turn_accum - TURN_COUNTS;
        turn_wraps++;
      end
      last_raw = raw;
      r.done_res = 1'b1;
      r.angle = raw - model_offset;
      r.error_flag = frame_bad(f);
      reads_done++;
      if (r.error_flag) reads_flagged++;
    end
    r.total_counts = turn_accum + {18'd0, last_raw};
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Send one input beat, with an optional idle gap in front of it.
  task automatic send_beat(input logic [1:0] c, input logic [15:0] f);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= c;
    in_ch.rx_frame <= f;
    do @(posedge clk); while (!in_ch.ready);
    sent_beats++;
    if (!(c == CMD_UNUSED || (c == samr_pkg::CMD_REPLY && rd_phase == samr_pkg::PH_IDLE)))
      useful_beats++;
    results_due.push_back(advance_reader(c, f));
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_results_home();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_wrap_threshold(input logic [13:0] v);
    wait_results_home();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    wrap_thresh = v;
    threshold_writes++;
  endtask

  // Occasionally disturb a read: zero offset, unused command, or a full drain.
  task automatic stir_sequence();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_beat(samr_pkg::CMD_ZERO, 16'($urandom));
    end else if (r < 5) begin
      send_beat(CMD_UNUSED, 16'($urandom));
    end else if (r < 6) begin
      wait_results_home();
    end
  endtask

  // A well-formed read, taking the recovery path when the data reply is bad.
  task automatic run_read_sequence();
    logic [13:0] a;
    send_beat(samr_pkg::CMD_START, 16'($urandom));
    stir_sequence();
    send_beat(samr_pkg::CMD_REPLY, 16'($urandom));
    stir_sequence();
    a = pick_angle();
    if ($urandom_range(0, 99) < 65) begin
      send_beat(samr_pkg::CMD_REPLY, good_reply(a));
    end else begin
      send_beat(samr_pkg::CMD_REPLY, bad_reply(a));
      repeat (3) begin
        stir_sequence();
        send_beat(samr_pkg::CMD_REPLY, 16'($urandom));
      end
      stir_sequence();
      a = pick_angle();
      send_beat(samr_pkg::CMD_REPLY,
                ($urandom_range(0, 3) != 0) ? good_reply(a) : bad_reply(a));
    end
  endtask

  // Random command mix; a start here often leaves a sequence unfinished.
  task automatic send_noise();
    repeat ($urandom_range(1, 5)) send_beat(2'($urandom), 16'($urandom));
  endtask

  task automatic run_reader_traffic(input int beats);
    int goal;
    goal = useful_beats + beats;
    while (useful_beats < goal) begin
      if ($urandom_range(0, 24) == 0) begin
        gaps_on  = ($urandom_range(0, 2) != 0);
        stall_on = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 99) < 80) run_read_sequence();
      else send_noise();
    end
  endtask

  // Hand-picked frames: ignored beats, wraps both ways, zero offset,
  // restart while busy, and the clear-and-retry path with bad retry data.
  task automatic test_directed_frames();
    send_beat(samr_pkg::CMD_REPLY, 16'hFFFF);
    send_beat(CMD_UNUSED, 16'h1234);
    send_beat(samr_pkg::CMD_START, 16'h0000);
    send_beat(samr_pkg::CMD_REPLY, 16'hFFFF);
    send_beat(samr_pkg::CMD_REPLY, good_reply(14'h3FFF));
    send_beat(samr_pkg::CMD_START, 16'hFFFF);
    send_beat(samr_pkg::CMD_REPLY, 16'h0000);
    send_beat(samr_pkg::CMD_REPLY, good_reply(14'h0005));
    send_beat(samr_pkg::CMD_ZERO, 16'h0000);
    send_beat(samr_pkg::CMD_START, 16'h0000);
    send_beat(samr_pkg::CMD_REPLY, 16'h0000);
    send_beat(samr_pkg::CMD_REPLY, good_reply(14'h0002));
    send_beat(samr_pkg::CMD_START, 16'h0000);
    send_beat(samr_pkg::CMD_REPLY, 16'h0000);
    send_beat(samr_pkg::CMD_ZERO, 16'h0000);
    wait_results_home();
    send_beat(samr_pkg::CMD_START, 16'h0000);
    send_beat(samr_pkg::CMD_REPLY, 16'h0000);
    send_beat(samr_pkg::CMD_REPLY, good_reply(14'h2000));
    send_beat(samr_pkg::CMD_START, 16'h0000);
    send_beat(samr_pkg::CMD_REPLY, 16'h0000);
    send_beat(samr_pkg::CMD_REPLY, {1'b1, 1'b1, 14'h0000});
    send_beat(samr_pkg::CMD_REPLY, 16'hFFFF);
    send_beat(samr_pkg::CMD_REPLY, 16'h0000);
    send_beat(samr_pkg::CMD_REPLY, 16'hAAAA);
    send_beat(samr_pkg::CMD_REPLY, good_reply(14'h3FF0) ^ 16'h8000);
  endtask

  // Range ends of the threshold, the reset value, and zero below the range.
  task automatic test_threshold_extremes();
    set_wrap_threshold(samr_pkg::WRAP_THRESHOLD_RESET);
    run_reader_traffic(PHASE_BEATS);
    set_wrap_threshold(14'd8192);
    run_reader_traffic(PHASE_BEATS);
    set_wrap_threshold(14'd16383);
    run_reader_traffic(PHASE_BEATS);
    set_wrap_threshold(14'd0);
    run_reader_traffic(PHASE_BEATS);
  endtask

  task automatic test_random_thresholds();
    set_wrap_threshold(14'($urandom_range(8192, 16383)));
    run_reader_traffic(PHASE_BEATS);
    set_wrap_threshold(14'($urandom));
    run_reader_traffic(PHASE_BEATS);
  endtask

  // Result side: random stalls, mostly short with the odd long one.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 99) < 20) begin
      out_ch.ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin : check_results
    reader_beat_t want;
    reader_beat_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.send_valid, out_ch.send_frame, out_ch.done_res, out_ch.angle,
              out_ch.total_counts, out_ch.error_flag};
      if (results_due.size() == 0) begin
        report_mismatch("result beat with no prediction outstanding");
      end else begin
        want = results_due.pop_front();
        if (got.send_valid !== want.send_valid)
          report_mismatch($sformatf("send_valid %0b, want %0b", got.send_valid,
                                    want.send_valid));
        if (got.send_frame !== want.send_frame)
          report_mismatch($sformatf("send_frame %h, want %h", got.send_frame,
                                    want.send_frame));
        if (got.done_res !== want.done_res)
          report_mismatch($sformatf("done_res %0b, want %0b", got.done_res, want.done_res));
        if (got.angle !== want.angle)
          report_mismatch($sformatf("angle %0d, want %0d", got.angle, want.angle));
        if (got.total_counts !== want.total_counts)
          report_mismatch($sformatf("total_counts %h, want %h", got.total_counts,
                                    want.total_counts));
        if (got.error_flag !== want.error_flag)
          report_mismatch($sformatf("error_flag %0b, want %0b", got.error_flag,
                                    want.error_flag));
      end
    end
  end

  // Main sequence.
  initial begin
    int waited;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = samr_pkg::CMD_START;
    in_ch.rx_frame = '0;
    out_ch.ready   = 1'b0;
    rd_phase       = samr_pkg::PH_IDLE;
    last_raw       = '0;
    model_offset   = '0;
    turn_accum     = '0;
    wrap_thresh    = samr_pkg::WRAP_THRESHOLD_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_threshold_extremes();
    test_random_thresholds();

    // Let the pipeline empty, then keep watching for stray beats.
    in_ch.valid <= 1'b0;
    waited = 0;
    while (results_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", results_due.size()));

    $display("Summary: %0d beats sent (%0d acted on), %0d angle reads completed, %0d flagged.",
             sent_beats, useful_beats, reads_done, reads_flagged);
    $display("Summary: %0d error recoveries, %0d turn wraps, %0d threshold writes.",
             recoveries, turn_wraps, threshold_writes);
    if (errors == 0) begin
      $display("tb_spi_angle_sensor_multiturn_reader OK");
    end else begin
      $display("tb_spi_angle_sensor_multiturn_reader NOT OK");
    end
    $finish;
  end

endmodule
